[rtl/postfix_expression_evaluator_macros.svh]
// Assertion macros for the postfix evaluator RTL.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define PFX_ASSERT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PFX_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PFX_ASSERT(label, clk, rstn, ante, cons, msg)
`define PFX_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

[rtl/pfx_pkg.sv]
// Types, codes and helpers for the postfix expression evaluator.
package pfx_pkg;

    localparam int DATA_W          = 32;
    localparam int SYM_W           = 8;
    localparam int DEF_STACK_DEPTH = 64;

    localparam logic [SYM_W-1:0] SYM_ADD  = 8'd43;
    localparam logic [SYM_W-1:0] SYM_SUB  = 8'd45;
    localparam logic [SYM_W-1:0] SYM_MUL  = 8'd42;
    localparam logic [SYM_W-1:0] SYM_DIV  = 8'd47;
    localparam logic [SYM_W-1:0] SYM_ZERO = 8'd48;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_UNDER   = 2'd1,
        ERR_OVER    = 2'd2,
        ERR_DIVZERO = 2'd3
    } pfx_err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_L,
        ST_EXEC,
        ST_DIV,
        ST_PUSH,
        ST_FINAL,
        ST_OUT
    } pfx_state_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } pfx_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [1:0]               status;
    } pfx_out_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } pfx_div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } pfx_div_rsp_t;

    function automatic logic is_operator(input logic [SYM_W-1:0] sym);
        logic op;
        unique case (sym) inside
            SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV: op = 1'b1;
            default:                            op = 1'b0;
        endcase
        return op;
    endfunction

    // First error of an expression sticks.
    function automatic pfx_err_t note_err(input pfx_err_t cur, input pfx_err_t code);
        pfx_err_t nxt;
        nxt = (cur == ERR_NONE) ? code : cur;
        return nxt;
    endfunction

endpackage

[rtl/pfx_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module pfx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/pfx_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module pfx_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pfx_pkg::pfx_div_req_t req,
    output pfx_pkg::pfx_div_rsp_t rsp
);
    import pfx_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic              neg_reg,   neg_next;
    logic [DATA_W-1:0] rem_reg,   rem_next;
    logic [DATA_W-1:0] quo_reg,   quo_next;
    logic [DATA_W-1:0] divisor_abs_reg;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   rem_sub;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        rem_sh    = {rem_reg, quo_reg[DATA_W-1]};
        rem_sub   = rem_sh - {1'b0, divisor_abs_reg};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_W - 1);
            neg_next  = req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
            rem_next  = '0;
            quo_next  = req.dividend[DATA_W-1] ? (DATA_W'(0) - req.dividend) : req.dividend;
        end else if (busy_reg) begin
            // restoring step: shift in the next dividend bit, subtract if it fits
            if (!rem_sub[DATA_W]) begin
                rem_next = rem_sub[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start) begin
            divisor_abs_reg <= req.divisor[DATA_W-1] ? (DATA_W'(0) - req.divisor)
                                                     : req.divisor;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

[rtl/postfix_expression_evaluator.sv]
// Postfix (RPN) expression evaluator: top level with stack control and result register.
//
// Characters arrive one per transaction on the s_ channel; + - * / are operators and
// any other byte is a digit operand pushed as (byte - 48). Operators pop right, then
// left, and push the wrapping 32-bit sum, difference, product or the quotient
// truncated toward zero. The transaction flagged last ends the expression: its
// character is handled, the top of stack is popped and sent on the m_ channel with
// the first error of the expression (underflow, overflow, divide by zero), and the
// stack and status are cleared for the next expression. Popping an empty stack
// gives 0, pushing onto a full stack drops the value, dividing by zero gives 0.
// An operand is pushed as it is accepted; + - * step through right pop, left pop,
// execute and push, the pops waiting on the registered read data of the stack RAM;
// / also waits on the 32-step bit-serial divider; the last character adds the final
// pop and the output state, plus any wait for the output register to empty. One
// character is in flight at a time. The stack needs no clearing pass: entries
// above the depth counter are never read.

module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfx_pkg::DEF_STACK_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pfx_pkg::pfx_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output pfx_pkg::pfx_out_t m_payload
);
    import pfx_pkg::*;

`include "postfix_expression_evaluator_macros.svh"

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    // control state
    pfx_state_t        state_reg,  state_next;
    logic [DW-1:0]     depth_reg,  depth_next;
    pfx_err_t          err_reg,    err_next;
    logic              m_valid_reg, m_valid_next;

    // payload state
    logic [SYM_W-1:0]  sym_reg,    sym_next;
    logic              last_reg,   last_next;
    logic              pop_ok_reg, pop_ok_next;
    logic [DATA_W-1:0] right_reg,  right_next;
    logic [DATA_W-1:0] res_reg,    res_next;
    pfx_out_t          out_reg,    out_next;

    // stack RAM port
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    pfx_div_req_t      div_req;
    pfx_div_rsp_t      div_rsp;

    logic [DW-1:0]     depth_dec;
    logic              stack_full;
    logic              stack_empty;
    logic [DATA_W-1:0] popped;
    logic              out_free;
    logic              accept;

    assign depth_dec   = depth_reg - 1'b1;
    assign stack_full  = (depth_reg >= DW'(STACK_DEPTH));
    assign stack_empty = (depth_reg == '0);
    // value of the most recent pop; an empty pop reads as zero
    assign popped      = pop_ok_reg ? mem_rdata : '0;
    assign out_free    = !m_valid_reg || m_ready;
    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;

    pfx_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pfx_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next   = state_reg;
        depth_next   = depth_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg && !m_ready;
        sym_next     = sym_reg;
        last_next    = last_reg;
        pop_ok_next  = pop_ok_reg;
        right_next   = right_reg;
        res_next     = res_reg;
        out_next     = out_reg;

        mem_we       = 1'b0;
        mem_waddr    = depth_reg[AW-1:0];
        mem_wdata    = res_reg;
        mem_re       = 1'b0;
        mem_raddr    = depth_dec[AW-1:0];

        div_req.start    = 1'b0;
        div_req.dividend = popped;
        div_req.divisor  = right_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    sym_next  = s_payload.symbol;
                    last_next = s_payload.last;
                    if (is_operator(s_payload.symbol)) begin
                        // pop the right operand
                        if (!stack_empty) begin
                            mem_re      = 1'b1;
                            depth_next  = depth_dec;
                            pop_ok_next = 1'b1;
                        end else begin
                            pop_ok_next = 1'b0;
                            err_next    = note_err(err_reg, ERR_UNDER);
                        end
                        state_next = ST_POP_L;
                    end else begin
                        // digit operand, pushed straight away
                        mem_wdata = {{(DATA_W-SYM_W){1'b0}}, s_payload.symbol}
                                    - DATA_W'(SYM_ZERO);
                        if (!stack_full) begin
                            mem_we     = 1'b1;
                            depth_next = depth_reg + 1'b1;
                        end else begin
                            err_next = note_err(err_reg, ERR_OVER);
                        end
                        state_next = s_payload.last ? ST_FINAL : ST_IDLE;
                    end
                end
            end
            ST_POP_L: begin
                right_next = popped;
                if (!stack_empty) begin
                    mem_re      = 1'b1;
                    depth_next  = depth_dec;
                    pop_ok_next = 1'b1;
                end else begin
                    pop_ok_next = 1'b0;
                    err_next    = note_err(err_reg, ERR_UNDER);
                end
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_PUSH;
                unique case (sym_reg)
                    SYM_ADD: res_next = popped + right_reg;
                    SYM_SUB: res_next = popped - right_reg;
                    SYM_MUL: res_next = DATA_W'(popped * right_reg);
                    default: begin
                        if (right_reg == '0) begin
                            err_next = note_err(err_reg, ERR_DIVZERO);
                            res_next = '0;
                        end else begin
                            div_req.start = 1'b1;
                            state_next    = ST_DIV;
                        end
                    end
                endcase
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    res_next   = div_rsp.quotient;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!stack_full) begin
                    mem_we     = 1'b1;
                    depth_next = depth_reg + 1'b1;
                end else begin
                    err_next = note_err(err_reg, ERR_OVER);
                end
                state_next = last_reg ? ST_FINAL : ST_IDLE;
            end
            ST_FINAL: begin
                // final pop of the expression result
                if (!stack_empty) begin
                    mem_re      = 1'b1;
                    depth_next  = depth_dec;
                    pop_ok_next = 1'b1;
                end else begin
                    pop_ok_next = 1'b0;
                    err_next    = note_err(err_reg, ERR_UNDER);
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // RAM read data holds while we wait for the output register
                if (out_free) begin
                    out_next.value  = popped;
                    out_next.status = err_reg;
                    m_valid_next    = 1'b1;
                    depth_next      = '0;
                    err_next        = ERR_NONE;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            depth_reg   <= '0;
            err_reg     <= ERR_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg    <= sym_next;
        last_reg   <= last_next;
        pop_ok_reg <= pop_ok_next;
        right_reg  <= right_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    `PFX_ASSERT(a_depth_bound, aclk, aresetn, 1'b1, depth_reg <= DW'(STACK_DEPTH), "stack depth beyond capacity")
    `PFX_ASSERT(a_write_room, aclk, aresetn, mem_we, !stack_full, "stack write while full")
    `PFX_ASSERT(a_div_nonzero, aclk, aresetn, div_req.start, div_req.divisor != '0, "divider started with zero divisor")
    `PFX_ASSERT_NEXT(a_clear_after_result, aclk, aresetn, (state_reg == ST_OUT) && out_free, (depth_reg == '0) && (err_reg == ERR_NONE) && m_valid_reg, "expression state not cleared after result")
    `PFX_ASSERT_NEXT(a_err_sticky, aclk, aresetn, (err_reg != ERR_NONE) && (state_reg != ST_OUT), $stable(err_reg), "recorded error changed mid-expression")

endmodule

[verif/postfix_expression_evaluator_tb.sv]
// Self-checking testbench for the postfix expression evaluator.
`timescale 1ns / 100ps

module postfix_expression_evaluator_tb;
    import pfx_pkg::*;

    localparam int STACK_SLOTS   = DEF_STACK_DEPTH;
    // Allowance for the longest divide, plus the final pop and the output register.
    localparam int SETTLE_CYCLES = 48;
    // The slowest correct run is roughly 850 symbols; the cycle limit is several
    // times what that run takes.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 525;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    pfx_in_t  s_payload;
    logic     m_valid;
    logic     m_ready;
    pfx_out_t m_payload;

    // Shadow copy of the evaluator state, advanced once per symbol sent.
    logic [DATA_W-1:0] calc_stack [STACK_SLOTS];
    int                calc_depth;
    pfx_err_t          calc_err;

    // Results still owed by the DUT, oldest first.
    pfx_out_t expected_results[$];

    int mismatches;
    int cycle_count;
    int symbols_sent;
    // Per-transaction idle draws are taken from 0 up to these bounds.
    // Setting a bound to 0 gives a stretch at full rate.
    int gap_max;
    int stall_max;

    postfix_expression_evaluator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Only the first error of an expression sticks.
    function automatic void flag_error(input pfx_err_t code);
        if (calc_err == ERR_NONE) begin
            calc_err = code;
        end
    endfunction

    function automatic void push_operand(input logic [DATA_W-1:0] v);
        if (calc_depth >= STACK_SLOTS) begin
            flag_error(ERR_OVER);
        end else begin
            calc_stack[calc_depth] = v;
            calc_depth++;
        end
    endfunction

    // An empty pop gives 0. It never reads an entry that was not written.
    function automatic logic [DATA_W-1:0] pop_operand();
        if (calc_depth == 0) begin
            flag_error(ERR_UNDER);
            return '0;
        end
        calc_depth--;
        return calc_stack[calc_depth];
    endfunction

    // Sign-magnitude divide, truncating toward zero. Min / -1 wraps back to min.
    function automatic logic [DATA_W-1:0] trunc_quotient(input logic [DATA_W-1:0] num,
                                                         input logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] mag_n;
        logic [DATA_W-1:0] mag_d;
        logic [DATA_W-1:0] q;
        mag_n = num[DATA_W-1] ? -num : num;
        mag_d = den[DATA_W-1] ? -den : den;
        q     = mag_n / mag_d;
        return (num[DATA_W-1] ^ den[DATA_W-1]) ? -q : q;
    endfunction

    function automatic void evaluate_symbol(input logic [SYM_W-1:0] sym, input logic lst);
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] res;
        pfx_out_t          outcome;
        case (sym)
            SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV: begin
                rhs = pop_operand();
                lhs = pop_operand();
                case (sym)
                    SYM_ADD: res = lhs + rhs;
                    SYM_SUB: res = lhs - rhs;
                    SYM_MUL: res = lhs * rhs;
                    default: begin
                        if (rhs == '0) begin
                            flag_error(ERR_DIVZERO);
                            res = '0;
                        end else begin
                            res = trunc_quotient(lhs, rhs);
                        end
                    end
                endcase
                push_operand(res);
            end
            // Any other byte is a digit; a byte below '0' wraps negative.
            default: push_operand({{(DATA_W-SYM_W){1'b0}}, sym} - {{(DATA_W-SYM_W){1'b0}}, SYM_ZERO});
        endcase
        if (lst) begin
            outcome.value  = pop_operand();
            outcome.status = calc_err;
            expected_results.push_back(outcome);
            calc_depth = 0;
            calc_err   = ERR_NONE;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    // Called right after the previous transaction's accepting edge (or after an
    // idle). It drops valid for the gap and re-raises it only at a fresh
    // falling edge, so no step gets two assignments.
    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic lst);
        int gap;
        gap = $urandom_range(0, gap_max);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        evaluate_symbol(sym, lst);
        s_payload.symbol <= sym;
        s_payload.last   <= lst;
        s_valid          <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        symbols_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            send_symbol(text[i], i == text.len() - 1);
        end
    endtask

    // Sender goes quiet until every owed result has come back, then lets
    // the pipeline settle.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Result side: random stall before each transaction, then ready held
    // until a result is taken.
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = $urandom_range(0, stall_max);
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin : result_check
        pfx_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result value=%0d status=%0d",
                                          m_payload.value, m_payload.status));
            end else begin
                want = expected_results.pop_front();
                if (m_payload.value !== want.value) begin
                    report_mismatch($sformatf("value %0d, expected %0d",
                                              m_payload.value, want.value));
                end
                if (m_payload.status !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_payload.status, want.status));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generators
    // ------------------------------------------------------------------

    // Mostly real digits; now and then any non-operator byte.
    function automatic logic [SYM_W-1:0] pick_operand();
        logic [SYM_W-1:0] sym;
        if ($urandom_range(0, 9) < 8) begin
            sym = SYM_ZERO + SYM_W'($urandom_range(0, 9));
        end else begin
            sym = SYM_W'($urandom_range(0, 255));
            while (sym inside {SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV}) begin
                sym = SYM_W'($urandom_range(0, 255));
            end
        end
        return sym;
    endfunction

    function automatic logic [SYM_W-1:0] pick_operator();
        case ($urandom_range(0, 3))
            0:       return SYM_ADD;
            1:       return SYM_SUB;
            2:       return SYM_MUL;
            default: return SYM_DIV;
        endcase
    endfunction

    // Three out of four expressions are well formed with random content.
    // A rare deep one pushes everything first, sometimes running past the stack limit.
    // The rest are raw bytes or operator-heavy sequences that tend to underflow.
    task automatic send_random_expression();
        int               kind;
        int               operands;
        int               pushed;
        int               live;
        int               len;
        logic             deep;
        logic             done;
        logic [SYM_W-1:0] sym;
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
            deep     = ($urandom_range(0, 39) == 0);
            operands = deep ? $urandom_range(60, 70) : $urandom_range(1, 8);
            pushed   = 0;
            live     = 0;
            done     = 1'b0;
            while (!done) begin
                if (pushed < operands && (deep || live < 2 || $urandom_range(0, 2) != 0)) begin
                    sym = pick_operand();
                    pushed++;
                    live++;
                end else begin
                    sym = pick_operator();
                    live--;
                end
                done = (pushed == operands && live <= 1);
                send_symbol(sym, done);
            end
        end else if (kind < 90) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                send_symbol(SYM_W'($urandom_range(0, 255)), i == len - 1);
            end
        end else begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                sym = $urandom_range(0, 1) ? pick_operator() : pick_operand();
                send_symbol(sym, i == len - 1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // All four operators, with truncation of a negative quotient toward zero,
    // and a lone operand as a whole expression.
    task automatic test_basic_operators();
        send_text("95-27*+");
        send_text("07-2/");
        send_text("9");
        drain_results();
    endtask

    // Symbol bytes 0x00 and 0xFF are treated as operands (-48 and 207).
    task automatic test_operand_extremes();
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(SYM_ADD, 1'b1);
        drain_results();
    endtask

    // 'p' is 64, so the chain builds 2^31, i.e. the most negative value; dividing
    // it by -1 must wrap back to itself.
    task automatic test_min_by_minus_one();
        send_text("pp*p*p*p*2*01-/");
        drain_results();
    endtask

    // Error cases: underflow, divide by zero, first-error-wins with underflow ahead of
    // divide by zero, and a divide-by-zero status that holds through later operators.
    task automatic test_error_status();
        send_text("+");
        send_text("50/");
        send_text("+50/");
        send_text("50/3+");
        drain_results();
    endtask

    // Fill the stack and push one more (dropped). Fold the rest with adds.
    // A following expression must start clean.
    task automatic test_stack_overflow();
        for (int i = 0; i <= STACK_SLOTS; i++) begin
            send_symbol(i == STACK_SLOTS ? SYM_ZERO + 8'd7 : SYM_ZERO + 8'd1, 1'b0);
        end
        for (int i = 0; i < STACK_SLOTS - 1; i++) begin
            send_symbol(SYM_ADD, i == STACK_SLOTS - 2);
        end
        send_text("34*");
        drain_results();
    endtask

    // Pacing changes now and then, including stretches with no idling on
    // either side.
    task automatic test_random_expressions();
        int stop_at;
        stop_at = symbols_sent + RANDOM_ITEMS;
        while (symbols_sent < stop_at) begin
            if ($urandom_range(0, 11) == 0) begin
                gap_max   = $urandom_range(0, 1) ? 10 : 0;
                stall_max = $urandom_range(0, 1) ? 10 : 0;
            end
            send_random_expression();
            // Occasionally let the block run dry mid-stream.
            if ($urandom_range(0, 29) == 0) begin
                drain_results();
            end
        end
        gap_max   = 10;
        stall_max = 10;
        drain_results();
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_payload    = '0;
        mismatches   = 0;
        cycle_count  = 0;
        symbols_sent = 0;
        gap_max      = 10;
        stall_max    = 10;
        calc_depth   = 0;
        calc_err     = ERR_NONE;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        test_basic_operators();
        test_operand_extremes();
        test_min_by_minus_one();
        test_error_status();
        test_stack_overflow();
        test_random_expressions();

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/pfx_pkg.sv
rtl/pfx_ram.sv
rtl/pfx_div.sv
rtl/postfix_expression_evaluator.sv
verif/postfix_expression_evaluator_tb.sv
